// ===== design/cdl_pkg.sv =====
// Shared types and constants for the cube map direction lookup unit.
// CORDIC arctangent table, face codes and the item record carried down the pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cdl_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CW           = 34;
  localparam int XW           = 33;
  localparam int MW           = 32;
  localparam int IN_TDATA_W   = 104;
  localparam int OUT_TDATA_W  = 56;

  typedef logic signed [CW-1:0] cord_t;

  localparam cord_t CORDIC_GAIN = 34'sd652032874;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [2:0] FACE_XP = 3'd0;
  localparam logic [2:0] FACE_XN = 3'd1;
  localparam logic [2:0] FACE_YP = 3'd2;
  localparam logic [2:0] FACE_YN = 3'd3;
  localparam logic [2:0] FACE_ZP = 3'd4;
  localparam logic [2:0] FACE_ZN = 3'd5;
  localparam logic [2:0] FACE_COUNT = 3'd6;

  typedef struct packed {
    logic        func;
    logic [2:0]  face;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [23:0] idx;
    logic [23:0] wgt;
  } item_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic cord_t atan_turn(input logic [3:0] i);
    cord_t r;
    case (i)
      4'd0:    r = 34'sh020000000;
      4'd1:    r = 34'sh012E4051E;
      4'd2:    r = 34'sh009FB385B;
      4'd3:    r = 34'sh0051111D4;
      4'd4:    r = 34'sh0028B0D43;
      4'd5:    r = 34'sh00145D7E1;
      4'd6:    r = 34'sh000A2F61E;
      4'd7:    r = 34'sh000517C55;
      4'd8:    r = 34'sh00028BE53;
      4'd9:    r = 34'sh000145F2F;
      4'd10:   r = 34'sh0000A2F98;
      4'd11:   r = 34'sh0000517CC;
      4'd12:   r = 34'sh000028BE6;
      4'd13:   r = 34'sh0000145F3;
      4'd14:   r = 34'sh00000A2F9;
      default: r = 34'sh00000517D;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/cubemap_direction_lookup_unit.sv =====
// Throughput: one item per cycle while the skid register is empty; every stage, including the
// texel memory port, takes one item.
// Reset: synchronous, active-low rst_n clears the stage valid bits and the output and skid
// valid bits. The texel tables are not cleared; an entry holds garbage until it is loaded.
// Top level of the cube map direction lookup; uses cdl_pkg for types, constants and the
// CORDIC table.
`timescale 1ns / 1ps
`default_nettype none
module cubemap_direction_lookup_unit #(
  parameter int FACE_SIZE  = 256,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0 up: polar_angle[15:0], azimuth_angle[31:16], load_face[34:32],
  // load_row[42:35], load_col[50:43], load_index_a/b/c[74:51], load_weight_a/b/c[98:75].
  input  wire logic [cdl_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Field: func (0 loads a texel, 1 looks up a direction).
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // Fields from bit 0 up: face_hit[2:0], dir_index_a/b/c[26:3], weight_a/b/c[50:27].
  output logic [cdl_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  // The pipeline is a single chain of stages that all advance together while the skid
  // register is empty. Loads ride the same chain so that they reach the memory in order
  // with the lookups around them.
  localparam int QB      = $clog2(FACE_SIZE);
  localparam int DEPTH   = 6 * FACE_SIZE * FACE_SIZE;
  localparam int AW      = $clog2(DEPTH);
  localparam int NW      = cdl_pkg::MW + QB;
  localparam int CW      = cdl_pkg::CW;
  localparam int XW      = cdl_pkg::XW;
  localparam int MW      = cdl_pkg::MW;
  localparam int NSTEP   = cdl_pkg::CORDIC_STEPS;
  localparam int ST_RND  = NSTEP + 1;
  localparam int ST_MUL  = NSTEP + 2;
  localparam int ST_FACE = NSTEP + 3;
  localparam int ST_NUM  = NSTEP + 4;
  localparam int ST_TEX  = NSTEP + 5 + QB;
  localparam int ST_ADDR = NSTEP + 6 + QB;
  localparam int ST_MEM  = NSTEP + 7 + QB;
  localparam int NST     = NSTEP + 8 + QB;
  localparam logic [QB-1:0] TEX_MAX  = QB'(FACE_SIZE - 1);
  localparam logic [QB-1:0] TEX_HALF = QB'((FACE_SIZE - 1) / 2);
  localparam logic [31:0]   AMASK    = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  typedef logic signed [XW-1:0] vec_t;

  function automatic logic [31:0] scale_angle(input logic [15:0] f);
    logic [31:0] w;
    w = {16'd0, f} & AMASK;
    return w << (32 - ANGLE_BITS);
  endfunction

  function automatic logic signed [15:0] to_q15(input cdl_pkg::cord_t v);
    logic signed [CW:0] t;
    t = {v[CW-1], v} + (CW+1)'(16384);
    t = t >>> 15;
    if (t > 32767) begin
      return 16'sh7fff;
    end else if (t < -32768) begin
      return -16'sh8000;
    end
    return t[15:0];
  endfunction

  // Returns {sine, cosine} after folding the quadrant back in.
  function automatic logic [31:0] fold_quadrant(input logic [1:0] q,
                                                input cdl_pkg::cord_t x,
                                                input cdl_pkg::cord_t y);
    cdl_pkg::cord_t c;
    cdl_pkg::cord_t s;
    case (q)
      2'd0: begin
        c = x;
        s = y;
      end
      2'd1: begin
        c = -y;
        s = x;
      end
      2'd2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
    return {to_q15(s), to_q15(c)};
  endfunction

  logic pipe_en;
  logic vld_r [NST];
  cdl_pkg::item_t item_r [NST];
  cdl_pkg::item_t in_item;
  cdl_pkg::item_t face_item;

  // CORDIC state for theta (t) and phi (p); entry i holds the values before step i.
  cdl_pkg::cord_t tx_r [NSTEP+1];
  cdl_pkg::cord_t ty_r [NSTEP+1];
  cdl_pkg::cord_t tz_r [NSTEP+1];
  cdl_pkg::cord_t px_r [NSTEP+1];
  cdl_pkg::cord_t py_r [NSTEP+1];
  cdl_pkg::cord_t pz_r [NSTEP+1];
  logic [1:0]     tq_r [NSTEP+1];
  logic [1:0]     pq_r [NSTEP+1];
  cdl_pkg::cord_t tx_nxt [NSTEP+1];
  cdl_pkg::cord_t ty_nxt [NSTEP+1];
  cdl_pkg::cord_t tz_nxt [NSTEP+1];
  cdl_pkg::cord_t px_nxt [NSTEP+1];
  cdl_pkg::cord_t py_nxt [NSTEP+1];
  cdl_pkg::cord_t pz_nxt [NSTEP+1];
  logic [31:0]    ta;
  logic [31:0]    pa;

  logic signed [15:0] st_r, ct_r, sp_r, cp_r;
  logic [31:0]        tsc_nxt, psc_nxt;
  vec_t               x_r, y_r, z_r;
  vec_t               x_nxt, y_nxt, z_nxt;

  logic [2:0]     face_nxt;
  vec_t           ns_nxt, nt_nxt, ns_r, nt_r;
  logic [MW-1:0]  m_nxt, m_r;
  logic [MW-1:0]  ax, ay, az;

  logic signed [MW+1:0] sum_s, sum_t;
  logic [NW-1:0] rs_r [QB+1];
  logic [NW-1:0] rt_r [QB+1];
  logic [NW-1:0] dv_r [QB+1];
  logic [QB-1:0] qs_r [QB+1];
  logic [QB-1:0] qt_r [QB+1];
  logic          mz_r [QB+1];
  logic [NW-1:0] rs_nxt [QB+1];
  logic [NW-1:0] rt_nxt [QB+1];
  logic [QB-1:0] qs_nxt [QB+1];
  logic [QB-1:0] qt_nxt [QB+1];

  logic [QB-1:0] col_r, row_r;
  logic [AW-1:0] addr_r;
  logic          we_r;
  logic [47:0]   wdata_r;
  logic [AW-1:0] addr_nxt;
  logic          in_range;

  logic [23:0] idx_mem [DEPTH];
  logic [23:0] wgt_mem [DEPTH];
  logic [23:0] idx_rd_r, wgt_rd_r;

  logic                           res_valid;
  logic [cdl_pkg::OUT_TDATA_W-1:0] res_data;
  logic                           out_valid_r, skid_valid_r;
  logic [cdl_pkg::OUT_TDATA_W-1:0] out_data_r, skid_data_r;
  logic                           out_fire;

  // The chain stalls only when a finished result is parked in the skid register.
  assign pipe_en   = !skid_valid_r;
  assign in_tready = pipe_en;

  assign in_item.func = in_tuser;
  assign in_item.face = in_tdata[34:32];
  assign in_item.row  = in_tdata[42:35];
  assign in_item.col  = in_tdata[50:43];
  assign in_item.idx  = in_tdata[74:51];
  assign in_item.wgt  = in_tdata[98:75];
  assign ta = scale_angle(in_tdata[15:0]);
  assign pa = scale_angle(in_tdata[31:16]);

  // One CORDIC rotation step per stage, for both angles side by side.
  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    assign tx_nxt[i+1] = tz_r[i][CW-1] ? tx_r[i] + (ty_r[i] >>> i) : tx_r[i] - (ty_r[i] >>> i);
    assign ty_nxt[i+1] = tz_r[i][CW-1] ? ty_r[i] - (tx_r[i] >>> i) : ty_r[i] + (tx_r[i] >>> i);
    assign tz_nxt[i+1] = tz_r[i][CW-1] ? tz_r[i] + cdl_pkg::atan_turn(4'(i))
                                       : tz_r[i] - cdl_pkg::atan_turn(4'(i));
    assign px_nxt[i+1] = pz_r[i][CW-1] ? px_r[i] + (py_r[i] >>> i) : px_r[i] - (py_r[i] >>> i);
    assign py_nxt[i+1] = pz_r[i][CW-1] ? py_r[i] - (px_r[i] >>> i) : py_r[i] + (px_r[i] >>> i);
    assign pz_nxt[i+1] = pz_r[i][CW-1] ? pz_r[i] + cdl_pkg::atan_turn(4'(i))
                                       : pz_r[i] - cdl_pkg::atan_turn(4'(i));
  end
  assign tx_nxt[0] = cdl_pkg::CORDIC_GAIN;
  assign ty_nxt[0] = '0;
  assign tz_nxt[0] = CW'(ta[29:0]);
  assign px_nxt[0] = cdl_pkg::CORDIC_GAIN;
  assign py_nxt[0] = '0;
  assign pz_nxt[0] = CW'(pa[29:0]);

  assign tsc_nxt = fold_quadrant(tq_r[NSTEP], tx_r[NSTEP], ty_r[NSTEP]);
  assign psc_nxt = fold_quadrant(pq_r[NSTEP], px_r[NSTEP], py_r[NSTEP]);

  // Direction vector; every product is exact in Q2.30.
  assign x_nxt = XW'(st_r) * XW'(cp_r);
  assign y_nxt = -(XW'(st_r) * XW'(sp_r));
  assign z_nxt = XW'(ct_r) <<< 15;

  // Face selection: on a tie z beats y and y beats x; a zero major component is positive.
  always_comb begin
    ax = MW'(x_r[XW-1] ? -x_r : x_r);
    ay = MW'(y_r[XW-1] ? -y_r : y_r);
    az = MW'(z_r[XW-1] ? -z_r : z_r);
    if (az >= ax && az >= ay) begin
      m_nxt  = az;
      nt_nxt = -y_r;
      if (!z_r[XW-1]) begin
        face_nxt = cdl_pkg::FACE_ZP;
        ns_nxt   = x_r;
      end else begin
        face_nxt = cdl_pkg::FACE_ZN;
        ns_nxt   = -x_r;
      end
    end else if (ay >= ax) begin
      m_nxt  = ay;
      ns_nxt = x_r;
      if (!y_r[XW-1]) begin
        face_nxt = cdl_pkg::FACE_YP;
        nt_nxt   = z_r;
      end else begin
        face_nxt = cdl_pkg::FACE_YN;
        nt_nxt   = -z_r;
      end
    end else begin
      m_nxt  = ax;
      nt_nxt = -y_r;
      if (!x_r[XW-1]) begin
        face_nxt = cdl_pkg::FACE_XP;
        ns_nxt   = -z_r;
      end else begin
        face_nxt = cdl_pkg::FACE_XN;
        ns_nxt   = z_r;
      end
    end
  end

  // A lookup carries its selected face in the face field from the face stage on.
  always_comb begin
    face_item = item_r[ST_FACE-1];
    if (item_r[ST_FACE-1].func == cdl_pkg::FUNC_LOOKUP) begin
      face_item.face = face_nxt;
    end
  end

  assign sum_s = (MW+2)'(ns_r) + $signed({2'b00, m_r});
  assign sum_t = (MW+2)'(nt_r) + $signed({2'b00, m_r});

  // Restoring division, one quotient bit per stage, most significant bit first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    assign rs_nxt[j+1] = (rs_r[j] >= (dv_r[j] << B)) ? rs_r[j] - (dv_r[j] << B) : rs_r[j];
    assign rt_nxt[j+1] = (rt_r[j] >= (dv_r[j] << B)) ? rt_r[j] - (dv_r[j] << B) : rt_r[j];
    assign qs_nxt[j+1] = qs_r[j] | ((rs_r[j] >= (dv_r[j] << B)) ? QB'(1) << B : '0);
    assign qt_nxt[j+1] = qt_r[j] | ((rt_r[j] >= (dv_r[j] << B)) ? QB'(1) << B : '0);
  end
  assign rs_nxt[0] = NW'(sum_s[MW+1] ? '0 : sum_s[MW-1:0]) * NW'(FACE_SIZE - 1);
  assign rt_nxt[0] = NW'(sum_t[MW+1] ? '0 : sum_t[MW-1:0]) * NW'(FACE_SIZE - 1);
  assign qs_nxt[0] = '0;
  assign qt_nxt[0] = '0;

  // A load writes only when the face, row and column all fall inside the table.
  assign in_range = (item_r[ST_TEX].face < cdl_pkg::FACE_COUNT)
                 && (32'(item_r[ST_TEX].row) < 32'(FACE_SIZE))
                 && (32'(item_r[ST_TEX].col) < 32'(FACE_SIZE));

  always_comb begin
    if (item_r[ST_TEX].func == cdl_pkg::FUNC_LOOKUP) begin
      addr_nxt = AW'((AW'(item_r[ST_TEX].face) * AW'(FACE_SIZE) + AW'(row_r))
                     * AW'(FACE_SIZE) + AW'(col_r));
    end else begin
      addr_nxt = AW'((AW'(item_r[ST_TEX].face) * AW'(FACE_SIZE) + AW'(item_r[ST_TEX].row))
                     * AW'(FACE_SIZE) + AW'(item_r[ST_TEX].col));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (pipe_en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < NST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      item_r[0] <= in_item;
      for (int k = 1; k < NST; k++) begin
        if (k == ST_FACE) begin
          item_r[k] <= face_item;
        end else begin
          item_r[k] <= item_r[k-1];
        end
      end

      tq_r[0] <= ta[31:30];
      pq_r[0] <= pa[31:30];
      for (int i = 0; i <= NSTEP; i++) begin
        tx_r[i] <= tx_nxt[i];
        ty_r[i] <= ty_nxt[i];
        tz_r[i] <= tz_nxt[i];
        px_r[i] <= px_nxt[i];
        py_r[i] <= py_nxt[i];
        pz_r[i] <= pz_nxt[i];
      end
      for (int i = 1; i <= NSTEP; i++) begin
        tq_r[i] <= tq_r[i-1];
        pq_r[i] <= pq_r[i-1];
      end

      {st_r, ct_r} <= tsc_nxt;
      {sp_r, cp_r} <= psc_nxt;
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      ns_r <= ns_nxt;
      nt_r <= nt_nxt;
      m_r  <= m_nxt;

      dv_r[0] <= NW'(m_r) << 1;
      mz_r[0] <= (m_r == '0);
      for (int j = 0; j <= QB; j++) begin
        rs_r[j] <= rs_nxt[j];
        rt_r[j] <= rt_nxt[j];
        qs_r[j] <= qs_nxt[j];
        qt_r[j] <= qt_nxt[j];
      end
      for (int j = 1; j <= QB; j++) begin
        dv_r[j] <= dv_r[j-1];
        mz_r[j] <= mz_r[j-1];
      end

      col_r <= mz_r[QB] ? TEX_HALF : ((qs_r[QB] > TEX_MAX) ? TEX_MAX : qs_r[QB]);
      row_r <= mz_r[QB] ? TEX_HALF : ((qt_r[QB] > TEX_MAX) ? TEX_MAX : qt_r[QB]);

      addr_r  <= addr_nxt;
      we_r    <= vld_r[ST_TEX] && (item_r[ST_TEX].func == cdl_pkg::FUNC_LOAD) && in_range;
      wdata_r <= {item_r[ST_TEX].wgt, item_r[ST_TEX].idx};
    end
  end

  // Texel tables: one port, written by loads and read by lookups at the same stage.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      if (we_r && vld_r[ST_ADDR]) begin
        idx_mem[addr_r] <= wdata_r[23:0];
        wgt_mem[addr_r] <= wdata_r[47:24];
      end else begin
        idx_rd_r <= idx_mem[addr_r];
        wgt_rd_r <= wgt_mem[addr_r];
      end
    end
  end

  assign res_valid = vld_r[ST_MEM] && (item_r[ST_MEM].func == cdl_pkg::FUNC_LOOKUP);
  assign res_data  = {5'd0, wgt_rd_r, idx_rd_r, item_r[ST_MEM].face};
  assign out_fire  = out_valid_r && out_tready;

  // Output register plus skid register: the chain keeps moving while one result waits in the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= res_data;
      end else begin
        skid_data_r <= res_data;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
